### hdl/tabx_pkg.sv
// Package for the tab expander: field widths, character codes, register reset
// values, controller state type and the controller/datapath command structs.
// No dependencies.
`default_nettype none

package tabx_pkg;

    localparam int CHAR_W           = 8;
    localparam int WID_W            = 6;
    localparam int SLOT_W           = 3;
    localparam int CFG_IDX_W        = 4;
    localparam int DEF_WIDTH_SLOTS  = 8;
    localparam int DEF_COLUMN_LIMIT = 1023;

    localparam logic [CHAR_W-1:0] TAB_CHAR     = 8'd9;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
    localparam logic [WID_W-1:0]  WIDTH0_RESET = 6'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // take the input beat
        logic start_count;  // set the blank count from the remainder
        logic emit;         // write one beat to the output register
    } tabx_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_tab;       // input beat carries a tab
        logic rem_done;     // remainder unit finished
        logic out_free;     // output register can take a beat
        logic last_beat;    // the beat to emit is the final one of the item
    } tabx_sts_t;

endpackage

`default_nettype wire

### hdl/tabx_rem.sv
// Bit-serial restoring remainder unit: column modulo tab width, one dividend
// bit per cycle. Depends on tabx_pkg.
`default_nettype none

module tabx_rem
    import tabx_pkg::*;
#(
    parameter int DIVIDEND_W = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [WID_W-1:0]      divisor,
    output logic                       done,
    output logic [WID_W-1:0]           remainder
);

    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [WID_W-1:0]      rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [WID_W:0]        partial;
    logic [WID_W:0]        diff;

    // Shift in the next dividend bit and subtract when it fits
    always_comb
    begin
        partial   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = partial - {1'b0, divisor};
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = (partial >= {1'b0, divisor}) ? diff[WID_W-1:0] : partial[WID_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign done      = !busy_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### hdl/tabx_dpath.sv
// Datapath of the tab expander: width registers, column and slot state,
// blank counter, remainder unit and output register. Depends on tabx_pkg, tabx_rem.
`default_nettype none

module tabx_dpath
    import tabx_pkg::*;
#(
    parameter int WIDTH_SLOTS  = DEF_WIDTH_SLOTS,
    parameter int COLUMN_LIMIT = DEF_COLUMN_LIMIT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tabx_cmd_t            cmd,
    output tabx_sts_t                 sts,
    input  wire logic [CHAR_W-1:0]    in_char,
    input  wire logic                 in_line_end,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WID_W-1:0]     cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [CHAR_W-1:0]         out_char,
    output logic                      out_run_last,
    output logic                      out_line_last
);

    localparam int COL_W = $clog2(COLUMN_LIMIT + 1);

    logic [WID_W-1:0]  width_reg [WIDTH_SLOTS];
    logic [COL_W-1:0]  column_reg, column_next;
    logic [SLOT_W-1:0] width_slot_reg, width_slot_next;
    logic [CHAR_W-1:0] char_reg;
    logic              eol_reg;
    logic              tab_reg;
    logic [WID_W-1:0]  w_reg;
    logic [WID_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_run_reg;
    logic              out_line_reg;

    logic [WID_W-1:0]  w_slot;
    logic [WID_W-1:0]  w_eff;
    logic [SLOT_W-1:0] slot_eff;
    logic [SLOT_W:0]   slot_inc;
    logic [SLOT_W-1:0] slot_after;
    logic              rem_done;
    logic [WID_W-1:0]  rem;

    // Write the width registers; indexes past the stored slots are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIDTH_SLOTS; i++)
            begin
                width_reg[i] <= (i == 0) ? WIDTH0_RESET : '0;
            end
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < WIDTH_SLOTS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    width_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Pick the width for the next tab and the slot that follows it
    always_comb
    begin
        w_slot = '0;
        for (int i = 0; i < WIDTH_SLOTS; i++)
        begin
            if (width_slot_reg == SLOT_W'(i))
            begin
                w_slot = width_reg[i];
            end
        end
        slot_eff = width_slot_reg;
        w_eff    = w_slot;
        if (w_slot == '0)
        begin
            slot_eff = '0;
            w_eff    = (width_reg[0] == '0) ? WID_W'(1) : width_reg[0];
        end
        slot_inc   = {1'b0, slot_eff} + 1'b1;
        slot_after = (slot_inc >= (SLOT_W + 1)'(WIDTH_SLOTS)) ? '0 : slot_inc[SLOT_W-1:0];
    end

    tabx_rem #(
        .DIVIDEND_W (COL_W)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.load && sts.in_tab),
        .dividend  (column_reg),
        .divisor   (w_reg),
        .done      (rem_done),
        .remainder (rem)
    );

    // Advance column and slot; close the line after its final beat
    always_comb
    begin
        column_next     = column_reg;
        width_slot_next = width_slot_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg && !out_ready;
        if (cmd.load)
        begin
            cnt_next = WID_W'(1);
            if (sts.in_tab)
            begin
                width_slot_next = slot_after;
            end
        end
        if (cmd.start_count)
        begin
            cnt_next = w_reg - rem;
        end
        if (cmd.emit)
        begin
            m_valid_next = 1'b1;
            cnt_next     = cnt_reg - 1'b1;
            column_next  = (column_reg < COL_W'(COLUMN_LIMIT)) ? column_reg + 1'b1 :
                           COL_W'(COLUMN_LIMIT);
            if (sts.last_beat && eol_reg)
            begin
                column_next     = '0;
                width_slot_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg     <= '0;
            width_slot_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            column_reg     <= column_next;
            width_slot_reg <= width_slot_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Hold the accepted beat and the output payload
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        if (cmd.load)
        begin
            char_reg <= in_char;
            eol_reg  <= in_line_end;
            tab_reg  <= sts.in_tab;
            w_reg    <= w_eff;
        end
        if (cmd.emit)
        begin
            out_char_reg <= tab_reg ? BLANK_CHAR : char_reg;
            out_run_reg  <= sts.last_beat;
            out_line_reg <= sts.last_beat && eol_reg;
        end
    end

    assign sts.in_tab    = (in_char == TAB_CHAR);
    assign sts.rem_done  = rem_done;
    assign sts.out_free  = !m_valid_reg || out_ready;
    assign sts.last_beat = (cnt_reg == WID_W'(1));

    assign out_valid     = m_valid_reg;
    assign out_char      = out_char_reg;
    assign out_run_last  = out_run_reg;
    assign out_line_last = out_line_reg;

    a_emit_free : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("beat emitted into a full output register");

    a_col_limit : assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= COL_W'(COLUMN_LIMIT))
        else $error("column beyond its limit");

    a_line_close : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && sts.last_beat && eol_reg |=> column_reg == '0 && width_slot_reg == '0)
        else $error("column or slot not cleared at line end");

endmodule

`default_nettype wire

### hdl/tabx_ctrl.sv
// Controller of the tab expander: sequences accept, remainder and emit phases.
// Depends on tabx_pkg.
`default_nettype none

module tabx_ctrl
    import tabx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire tabx_sts_t sts,
    output tabx_cmd_t      cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd.load        = 1'b0;
        cmd.start_count = 1'b0;
        cmd.emit        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_tab ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV:
            begin
                if (sts.rem_done)
                begin
                    cmd.start_count = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_beat)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_div_wait : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && !sts.rem_done |=> state_reg == ST_DIV)
        else $error("left remainder phase early");

endmodule

`default_nettype wire

### hdl/tab_expander_cyclic_widths.sv
// Top level of the tab expander with a cyclic list of tab widths.
// Depends on tabx_pkg, tabx_ctrl, tabx_dpath (which holds tabx_rem).
`default_nettype none

// One character is taken per input beat. A non-tab character comes out
// unchanged; a tab comes out as blanks up to the next multiple of the current
// tab width, taken from width registers 0..WIDTH_SLOTS-1 in turn (a zero width
// or the end of the list wraps to register 0). s_tlast marks the last
// character of a line: after its beats the column and the width slot return
// to zero. The column saturates at COLUMN_LIMIT. A non-tab character is
// accepted, then emitted. A tab is accepted, then the bit-serial remainder
// unit works through the COL_W column bits ($clog2(COLUMN_LIMIT+1), 10 by
// default), then the blanks leave one per cycle at the output register while
// it is free; output stalls hold the emit phase only. The user writes width
// registers through the cfg port only while the block is idle; the block
// itself does not enforce it. cfg_ready is always high.
module tab_expander_cyclic_widths
    import tabx_pkg::*;
#(
    parameter int WIDTH_SLOTS  = DEF_WIDTH_SLOTS,
    parameter int COLUMN_LIMIT = DEF_COLUMN_LIMIT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [CHAR_W-1:0]    s_tdata,    // [7:0] char_in
    input  wire logic                 s_tlast,    // line_end
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [CHAR_W-1:0]         m_tdata,    // [7:0] char_out
    output logic                      m_tuser,    // [0] run_last
    output logic                      m_tlast,    // line_last
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WID_W-1:0]     cfg_data
);

    tabx_cmd_t cmd;
    tabx_sts_t sts;

    tabx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tabx_dpath #(
        .WIDTH_SLOTS  (WIDTH_SLOTS),
        .COLUMN_LIMIT (COLUMN_LIMIT)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_char       (s_tdata),
        .in_line_end   (s_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_char      (m_tdata),
        .out_run_last  (m_tuser),
        .out_line_last (m_tlast)
    );

    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

### verif/tabx_checker.sv
// Checker for the tab expander: mirrors the width registers, predicts the
// output beats of every accepted character and compares them with the output.
// Depends on tabx_pkg.
`default_nettype none

module tabx_checker
    import tabx_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [CHAR_W-1:0]    s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [CHAR_W-1:0]    m_tdata,
    input  wire logic                 m_tuser,
    input  wire logic                 m_tlast,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WID_W-1:0]     cfg_data,
    output int                        errors,
    output int                        outstanding
);

    localparam int NUM_WIDTHS  = 8;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              run_last;
        logic              line_last;
    } out_beat_t;

    logic [WID_W-1:0] widths [NUM_WIDTHS];
    int unsigned      column;
    int unsigned      slot;
    out_beat_t        due_beats [$];
    out_beat_t        head;

    // Queue the beats one character turns into and advance column and slot
    function automatic void expand_char(input logic [CHAR_W-1:0] ch, input logic eol);
        int unsigned s;
        int unsigned w;
        int unsigned n;
        out_beat_t   b;
        n = 1;
        if (ch == TAB_CHAR)
        begin
            s = slot;
            // a slot past the list or holding a zero width falls back to slot 0
            if (s >= DEF_WIDTH_SLOTS || widths[s] == '0)
                s = 0;
            w = widths[s];
            if (w == 0)
                w = 1;
            n = w - (column % w);
            s = s + 1;
            if (s >= DEF_WIDTH_SLOTS)
                s = 0;
            slot = s;
        end
        for (int k = 0; k < n; k++)
        begin
            b.ch        = (ch == TAB_CHAR) ? BLANK_CHAR : ch;
            b.run_last  = (k == n - 1);
            b.line_last = (k == n - 1) && eol;
            due_beats.push_back(b);
            // saturate the column, the tab arithmetic keeps using the clamped value
            if (column < DEF_COLUMN_LIMIT)
                column++;
        end
        if (eol)
        begin
            column = 0;
            slot   = 0;
        end
    endfunction

    task automatic flag(input string field, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Track register writes, predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WIDTHS; i++)
                widths[i] = '0;
            widths[0] = WIDTH0_RESET;
            column    = 0;
            slot      = 0;
            due_beats.delete();
            outstanding = 0;
            errors      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index < NUM_WIDTHS)
                widths[cfg_index] = cfg_data;
            if (s_tvalid && s_tready)
                expand_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (due_beats.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat, expected none, actual char %0d",
                             $time, m_tdata);
                end
                else
                begin
                    head = due_beats.pop_front();
                    if (m_tdata !== head.ch)
                        flag("char_out", head.ch, m_tdata);
                    if (m_tuser !== head.run_last)
                        flag("run_last", head.run_last, m_tuser);
                    if (m_tlast !== head.line_last)
                        flag("line_last", head.line_last, m_tlast);
                end
            end
            outstanding = due_beats.size();
        end
    end

endmodule

`default_nettype wire

### verif/tb_tab_expander_cyclic_widths.sv
// Testbench top for the tab expander: clock, reset, character stimulus, width
// programming and output stalls; tabx_checker does the prediction.
// Depends on tabx_pkg, tab_expander_cyclic_widths and tabx_checker.
`default_nettype none

module tb_tab_expander_cyclic_widths;
    import tabx_pkg::*;

    localparam int MAX_CYCLES      = 600000;
    localparam int SETTLE_CYCLES   = 80;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int NUM_WIDTH_REGS  = 8;
    localparam int LAST_CFG_INDEX  = (1 << CFG_IDX_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_0 = '0;

    typedef enum int {
        PLAN_RANDOM,
        PLAN_LARGE,
        PLAN_SHORT,
        PLAN_ZERO_FIRST,
        PLAN_EXTREME,
        PLAN_ONES,
        NUM_PLANS
    } plan_e;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } rx_mode_e;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [CHAR_W-1:0]    m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WID_W-1:0]     cfg_data  = '0;

    int                   errors;
    int                   outstanding;
    int                   cycles = 0;
    bit                   hold_req = 1'b0;
    int                   burst_left = 0;
    int                   gap_max = 3;
    logic [WID_W-1:0]     width_plan [NUM_WIDTH_REGS];

    always #1 clk = ~clk;

    tab_expander_cyclic_widths u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tabx_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == MAX_CYCLES)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Output side: switch between stall patterns, hold off on request
    initial
    begin : receiver
        rx_mode_e mode;
        int       left;
        int       tick;
        logic     rdy;
        mode = RX_OPEN;
        left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            if (left == 0)
            begin
                mode = rx_mode_e'($urandom_range(RX_OPEN, RX_CADENCE));
                left = $urandom_range(16, 96);
            end
            left--;
            tick++;
            case (mode)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:   rdy = (tick % 3 != 0);
            endcase
            m_tready <= rdy;
        end
    end

    // Offer one character beat, then maybe end the burst with a gap
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eol);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eol;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap        = $urandom_range(0, gap_max);
            burst_left = $urandom_range(0, 15);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and wait until every predicted beat has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all width registers from the plan, then a stray unmapped index
    task automatic load_widths();
        for (int i = 0; i < NUM_WIDTH_REGS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_WIDTH_0 + CFG_IDX_W'(i);
            cfg_data  <= width_plan[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_index <= CFG_IDX_W'($urandom_range(NUM_WIDTH_REGS, LAST_CFG_INDEX));
        cfg_data  <= WID_W'($urandom);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void fill_plan(input plan_e kind);
        int base;
        int cut;
        base = $urandom_range(48, 63);
        cut  = $urandom_range(1, NUM_WIDTH_REGS - 1);
        for (int i = 0; i < NUM_WIDTH_REGS; i++)
        begin
            case (kind)
                PLAN_LARGE:   width_plan[i] = WID_W'(base);
                PLAN_SHORT:   width_plan[i] = (i == cut) ? '0 : WID_W'($urandom_range(1, 63));
                PLAN_EXTREME: width_plan[i] = ($urandom_range(0, 3) == 0) ? '0 :
                                              ($urandom_range(0, 1) ? WID_W'(63) : WID_W'(1));
                PLAN_ONES:    width_plan[i] = WID_W'(1);
                default:      width_plan[i] = WID_W'($urandom_range(0, 63));
            endcase
        end
        // slot 0 stays nonzero except where its zero fallback is the point
        case (kind)
            PLAN_LARGE:      width_plan[NUM_WIDTH_REGS-1] = WID_W'($urandom_range(1, 63));
            PLAN_ZERO_FIRST: width_plan[0] = '0;
            PLAN_EXTREME:    width_plan[0] = $urandom_range(0, 1) ? WID_W'(63) : WID_W'(1);
            PLAN_ONES:       width_plan[0] = WID_W'(1);
            default:         width_plan[0] = WID_W'($urandom_range(1, 63));
        endcase
    endfunction

    // Send one line of random characters with tabs mixed in, closed by line_end
    task automatic send_line(input int len, input int tab_pct);
        for (int k = 0; k < len; k++)
            send_char(($urandom_range(0, 99) < tab_pct) ? TAB_CHAR : 8'($urandom),
                      k == len - 1);
    endtask

    initial
    begin : stimulus
        int sent;
        int len;
        plan_e kind;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset widths: single slot of 4
        send_char(8'h00, 1'b0);
        send_char(TAB_CHAR, 1'b0);
        send_char(TAB_CHAR, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(TAB_CHAR, 1'b1);
        send_char(8'h20, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(TAB_CHAR, 1'b1);
        settle();

        // Zero in slot 0 gives one blank; a zero later in the list wraps to slot 0
        for (int i = 0; i < NUM_WIDTH_REGS; i++)
            width_plan[i] = '0;
        width_plan[1] = 5;
        load_widths();
        send_char(TAB_CHAR, 1'b0);
        send_char(TAB_CHAR, 1'b0);
        send_char(TAB_CHAR, 1'b0);
        send_char(8'h78, 1'b1);
        settle();

        // Full list: walk all eight slots and wrap after the last one
        for (int i = 0; i < NUM_WIDTH_REGS; i++)
            width_plan[i] = WID_W'(i);
        width_plan[0] = 1;
        width_plan[1] = 63;
        load_widths();
        for (int i = 0; i < NUM_WIDTH_REGS + 1; i++)
            send_char(TAB_CHAR, 1'b0);
        send_char(8'h41, 1'b1);
        send_char(TAB_CHAR, 1'b1);
        settle();

        // Random phases, one width plan each
        for (int phase = 0; phase < NUM_PLANS; phase++)
        begin
            kind = plan_e'(phase);
            fill_plan(kind);
            load_widths();
            gap_max = (kind == PLAN_RANDOM) ? 0 : $urandom_range(2, 10);
            if (kind == PLAN_LARGE)
                hold_req = 1'b1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if (kind == PLAN_LARGE || $urandom_range(0, 4) == 0)
                begin
                    len = $urandom_range(30, 60);
                    send_line(len, 80);
                end
                else
                begin
                    len = $urandom_range(1, 12);
                    send_line(len, 25);
                end
                sent += len;
                // pause mid-phase until the output has drained
                if (kind == PLAN_SHORT && sent >= ITEMS_PER_PHASE / 2
                    && sent - len < ITEMS_PER_PHASE / 2)
                    settle();
            end
            settle();
        end

        if (errors == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
